/* hdl/iau_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package iau_pkg;

  localparam int W = 64;
  localparam int NDIV = 4;

  typedef enum logic [3:0] {
    ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
    ACT_MIN = 4'd4, ACT_MAX = 4'd5, ACT_ABS = 4'd6, ACT_UNION = 4'd7,
    ACT_CONTAINS = 4'd8
  } act_t;

  localparam logic signed [W-1:0] S64_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] S64_MIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [3:0]        action;
    logic signed [W-1:0] a_lo;
    logic signed [W-1:0] a_hi;
    logic              a_lo_valid;
    logic              a_hi_valid;
    logic signed [W-1:0] b_lo;
    logic signed [W-1:0] b_hi;
    logic              b_lo_valid;
    logic              b_hi_valid;
  } item_t;

  typedef struct packed {
    logic signed [W-1:0] r_lo;
    logic signed [W-1:0] r_hi;
    logic              r_lo_valid;
    logic              r_hi_valid;
    logic              point_inside;
  } res_t;

  // one division lane: dividend magnitude, divisor magnitude, quotient, partial remainder
  typedef struct packed {
    logic          en;
    logic          neg_q;
    logic          neg_n;
    logic          bneg;
    logic [W-1:0]  num;
    logic [W-1:0]  den;
    logic [W-1:0]  quo;
    logic [W:0]    rem;
  } dlane_t;

  typedef struct packed {
    logic          vld;
    item_t         it;
    logic [NDIV-1:0] ok;
    logic [NDIV-1:0][W-1:0] pr;
    logic [NDIV-1:0] ovp;
    dlane_t [NDIV-1:0] dl;
  } slot_t;

endpackage
`default_nettype wire

/* hdl/int64_interval_arithmetic_unit_core.sv */
`timescale 1ns / 1ps
// Pipeline: 2 multiply/setup stages, 64 divide cells one quotient bit each,
//   2 fix-up/select stages.
// Throughput: one beat per cycle; the whole cell chain advances together
//   and stalls only when the output register is full and not taken.
// Reset: rst_n synchronous active low clears every stage valid bit.
`default_nettype none
module int64_interval_arithmetic_unit_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [3:0] action, [67:4] a_lo, [131:68] a_hi, [132] a_lo_valid, [133] a_hi_valid,
  // [197:134] b_lo, [261:198] b_hi, [262] b_lo_valid, [263] b_hi_valid
  input  wire logic [263:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [63:0] r_lo, [127:64] r_hi, [128] r_lo_valid, [129] r_hi_valid,
  // [130] point_inside, [135:131] zero
  output logic [135:0]      out_tdata
);
  localparam int N = iau_pkg::W;

  iau_pkg::item_t it;
  iau_pkg::slot_t chain [N+1];
  iau_pkg::res_t  res;
  logic           vld;
  logic           en;

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  assign it.action     = in_tdata[3:0];
  assign it.a_lo       = in_tdata[67:4];
  assign it.a_hi       = in_tdata[131:68];
  assign it.a_lo_valid = in_tdata[132];
  assign it.a_hi_valid = in_tdata[133];
  assign it.b_lo       = in_tdata[197:134];
  assign it.b_hi       = in_tdata[261:198];
  assign it.b_lo_valid = in_tdata[262];
  assign it.b_hi_valid = in_tdata[263];

  iau_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_tvalid), .it_in(it),
    .d_out(chain[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    iau_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_in(chain[g]), .d_out(chain[g+1])
    );
  end

  iau_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .d_in(chain[N]),
    .vld_out(vld), .res_out(res)
  );

  assign out_tvalid = vld;
  assign out_tdata  = {5'b0, res.point_inside, res.r_hi_valid, res.r_lo_valid,
                       res.r_hi, res.r_lo};
endmodule
`default_nettype wire

/* hdl/iau_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// one restoring-division step on all four lanes; one bit per cell
module iau_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire iau_pkg::slot_t  d_in,
  output iau_pkg::slot_t       d_out
);
  iau_pkg::slot_t s_nxt;
  iau_pkg::slot_t s_r;
  logic [iau_pkg::W:0] t;

  always_comb begin
    s_nxt = d_in;
    for (int i = 0; i < iau_pkg::NDIV; i++) begin
      t = {d_in.dl[i].rem[iau_pkg::W-1:0], d_in.dl[i].num[iau_pkg::W-1]};
      s_nxt.dl[i].num = {d_in.dl[i].num[iau_pkg::W-2:0], 1'b0};
      if (t >= {1'b0, d_in.dl[i].den}) begin
        s_nxt.dl[i].rem = t - {1'b0, d_in.dl[i].den};
        s_nxt.dl[i].quo = {d_in.dl[i].quo[iau_pkg::W-2:0], 1'b1};
      end else begin
        s_nxt.dl[i].rem = t;
        s_nxt.dl[i].quo = {d_in.dl[i].quo[iau_pkg::W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r.vld <= s_nxt.vld;
    end
    if (en) begin
      s_r.it  <= s_nxt.it;
      s_r.ok  <= s_nxt.ok;
      s_r.pr  <= s_nxt.pr;
      s_r.ovp <= s_nxt.ovp;
      s_r.dl  <= s_nxt.dl;
    end
  end

  assign d_out = s_r;
endmodule
`default_nettype wire

/* hdl/iau_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// entry stages: corner products (32x32 partials then sums), divide lane setup
module iau_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            vld_in,
  input  wire iau_pkg::item_t  it_in,
  output iau_pkg::slot_t       d_out
);
  localparam int W = iau_pkg::W;
  localparam int H = W / 2;
  localparam int N = iau_pkg::NDIV;

  logic                 v1_r;
  iau_pkg::item_t       it1_r;
  logic [N-1:0][W-1:0]  p00_r, p01_r, p10_r, p11_r;
  logic [N-1:0]         neg1_r;
  logic [N-1:0][W-1:0]  ua, ub;
  logic [N-1:0]         neg;
  logic signed [N-1:0][W-1:0] xa, xb;

  iau_pkg::slot_t       s_nxt, s_r;
  logic [W:0]           mid;
  logic [W-1:0]         lo, hi;
  logic signed [W-1:0]  nu, de;

  function automatic logic [W-1:0] magn(input logic signed [W-1:0] v);
    magn = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    xa[0] = it_in.a_lo; xb[0] = it_in.b_lo;
    xa[1] = it_in.a_lo; xb[1] = it_in.b_hi;
    xa[2] = it_in.a_hi; xb[2] = it_in.b_lo;
    xa[3] = it_in.a_hi; xb[3] = it_in.b_hi;
    for (int i = 0; i < N; i++) begin
      ua[i]  = magn(xa[i]);
      ub[i]  = magn(xb[i]);
      neg[i] = xa[i][W-1] ^ xb[i][W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
    end
    if (en) begin
      it1_r  <= it_in;
      neg1_r <= neg;
      for (int i = 0; i < N; i++) begin
        p00_r[i] <= ua[i][H-1:0] * ub[i][H-1:0];
        p01_r[i] <= ua[i][H-1:0] * ub[i][W-1:H];
        p10_r[i] <= ua[i][W-1:H] * ub[i][H-1:0];
        p11_r[i] <= ua[i][W-1:H] * ub[i][W-1:H];
      end
    end
  end

  always_comb begin
    s_nxt = '0;
    s_nxt.vld = v1_r;
    s_nxt.it  = it1_r;
    for (int i = 0; i < N; i++) begin
      mid = {{(H+1){1'b0}}, p00_r[i][W-1:H]} + {{(H+1){1'b0}}, p01_r[i][H-1:0]}
          + {{(H+1){1'b0}}, p10_r[i][H-1:0]};
      lo  = {mid[H-1:0], p00_r[i][H-1:0]};
      hi  = p11_r[i] + {{H{1'b0}}, p01_r[i][W-1:H]} + {{H{1'b0}}, p10_r[i][W-1:H]}
          + {{(H-1){1'b0}}, mid[W:H]};
      s_nxt.ok[i] = 1'b0;
      s_nxt.pr[i] = '0;
      if (hi == '0) begin
        if (neg1_r[i]) begin
          if (lo <= iau_pkg::S64_MIN) begin
            s_nxt.ok[i] = 1'b1;
            s_nxt.pr[i] = ~lo + 1'b1;
          end
        end else if (!lo[W-1]) begin
          s_nxt.ok[i] = 1'b1;
          s_nxt.pr[i] = lo;
        end
      end
    end
    nu = '0; de = '0;
    s_nxt.ovp = '0;
    for (int i = 0; i < N; i++) begin
      case (i)
        0: begin nu = it1_r.a_lo; de = it1_r.b_lo; end
        1: begin nu = it1_r.a_lo; de = it1_r.b_hi; end
        2: begin nu = it1_r.a_hi; de = it1_r.b_lo; end
        default: begin nu = it1_r.a_hi; de = it1_r.b_hi; end
      endcase
      // sign for saturation: (a>0)==(b>0)
      s_nxt.ovp[i] = ((nu > 0) == (de > 0));
      s_nxt.dl[i].num   = magn(nu);
      s_nxt.dl[i].den   = magn(de);
      s_nxt.dl[i].neg_q = nu[W-1] ^ de[W-1];
      s_nxt.dl[i].neg_n = nu[W-1];
      s_nxt.dl[i].bneg  = de[W-1];
      s_nxt.dl[i].en    = (de != '0);
      s_nxt.dl[i].quo   = '0;
      s_nxt.dl[i].rem   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r.vld <= 1'b0;
    end else if (en) begin
      s_r.vld <= s_nxt.vld;
    end
    if (en) begin
      s_r.it  <= s_nxt.it;
      s_r.ok  <= s_nxt.ok;
      s_r.pr  <= s_nxt.pr;
      s_r.ovp <= s_nxt.ovp;
      s_r.dl  <= s_nxt.dl;
    end
  end

  assign d_out = s_r;
endmodule
`default_nettype wire

/* hdl/iau_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// final stages: quotient fix-up, then result select
module iau_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire iau_pkg::slot_t  d_in,
  output logic                 vld_out,
  output iau_pkg::res_t        res_out
);
  localparam int W = iau_pkg::W;
  localparam int N = iau_pkg::NDIV;
  typedef logic signed [W-1:0] s64_t;

  logic                 v1_r;
  iau_pkg::slot_t       d1_r;
  s64_t [N-1:0]         q_nxt, q_r;
  logic                 v2_r;
  iau_pkg::res_t        res_nxt, res_r;

  function automatic s64_t smin(input s64_t x, input s64_t y);
    smin = (x < y) ? x : y;
  endfunction
  function automatic s64_t smax(input s64_t x, input s64_t y);
    smax = (x > y) ? x : y;
  endfunction

  // Euclidean correction: negative remainder moves the quotient away from the divisor sign
  always_comb begin
    for (int i = 0; i < N; i++) begin
      logic [W-1:0] qt;
      qt = d_in.dl[i].neg_q ? (~d_in.dl[i].quo + 1'b1) : d_in.dl[i].quo;
      if (d_in.dl[i].neg_n && d_in.dl[i].rem != '0) begin
        qt = d_in.dl[i].bneg ? qt + 1'b1 : qt - 1'b1;
      end
      q_nxt[i] = qt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= d_in.vld;
      v2_r <= v1_r;
    end
    if (en) begin
      d1_r  <= d_in;
      q_r   <= q_nxt;
      res_r <= res_nxt;
    end
  end

  always_comb begin
    iau_pkg::item_t a;
    s64_t rlo, rhi, m, v;
    logic lov, hiv, apos, bpos, bneg, abnd, bbnd, nn, np, dn, dp;
    s64_t [N-1:0] cv;
    a = d1_r.it;
    rlo = '0; rhi = '0; lov = 1'b0; hiv = 1'b0; m = '0; v = '0;
    apos = a.a_lo_valid && (a.a_lo > 0);
    bpos = a.b_lo_valid && (a.b_lo > 0);
    bneg = a.b_hi_valid && (a.b_hi < 0);
    abnd = a.a_lo_valid && a.a_hi_valid;
    bbnd = a.b_lo_valid && a.b_hi_valid;
    nn = a.a_lo_valid && (a.a_lo >= 0);
    dn = a.b_lo_valid && (a.b_lo >= 0);
    np = a.a_hi_valid && (a.a_hi <= 0);
    dp = a.b_hi_valid && (a.b_hi <= 0);
    for (int i = 0; i < N; i++) begin
      cv[i] = d1_r.ok[i] ? s64_t'(d1_r.pr[i])
            : (d1_r.ovp[i] ? iau_pkg::S64_MAX : iau_pkg::S64_MIN);
    end
    res_nxt = '0;
    case (a.action)
      iau_pkg::ACT_ADD: begin
        v = a.a_lo + a.b_lo;
        lov = a.a_lo_valid && a.b_lo_valid &&
              !(a.a_lo[W-1] == a.b_lo[W-1] && v[W-1] != a.a_lo[W-1]);
        rlo = v;
        v = a.a_hi + a.b_hi;
        hiv = a.a_hi_valid && a.b_hi_valid &&
              !(a.a_hi[W-1] == a.b_hi[W-1] && v[W-1] != a.a_hi[W-1]);
        rhi = v;
      end
      iau_pkg::ACT_SUB: begin
        v = a.a_lo - a.b_hi;
        lov = a.a_lo_valid && a.b_hi_valid &&
              !(a.a_lo[W-1] != a.b_hi[W-1] && v[W-1] != a.a_lo[W-1]);
        rlo = v;
        v = a.a_hi - a.b_lo;
        hiv = a.a_hi_valid && a.b_lo_valid &&
              !(a.a_hi[W-1] != a.b_lo[W-1] && v[W-1] != a.a_hi[W-1]);
        rhi = v;
      end
      iau_pkg::ACT_MUL: begin
        if (abnd && bbnd) begin
          lov = 1'b1; hiv = 1'b1;
          for (int i = 0; i < N; i++) begin
            if (!d1_r.ok[i]) begin
              if (d1_r.ovp[i]) hiv = 1'b0;
              else lov = 1'b0;
            end
          end
          rlo = smin(smin(cv[0], cv[1]), smin(cv[2], cv[3]));
          rhi = smax(smax(cv[0], cv[1]), smax(cv[2], cv[3]));
        end else if ((a.a_hi_valid && bbnd && bpos) || (a.b_hi_valid && abnd && apos)) begin
          hiv = d1_r.ok[3] || !d1_r.ovp[3];
          rhi = cv[3];
        end else if ((a.a_lo_valid && bbnd && bpos) || (a.b_lo_valid && abnd && apos)) begin
          lov = d1_r.ok[0] || d1_r.ovp[0];
          rlo = cv[0];
        end
      end
      iau_pkg::ACT_DIV: begin
        rlo = iau_pkg::S64_MAX; rhi = iau_pkg::S64_MIN;
        if (a.a_lo_valid && a.b_lo_valid && d1_r.dl[0].en) begin
          rlo = smin(rlo, q_r[0]); rhi = smax(rhi, q_r[0]);
        end
        if (a.a_lo_valid && a.b_hi_valid && d1_r.dl[1].en) begin
          rlo = smin(rlo, q_r[1]); rhi = smax(rhi, q_r[1]);
        end
        if (a.a_hi_valid && a.b_hi_valid && d1_r.dl[3].en) begin
          rlo = smin(rlo, q_r[3]); rhi = smax(rhi, q_r[3]);
        end
        if (a.a_hi_valid && a.b_lo_valid && d1_r.dl[2].en) begin
          rlo = smin(rlo, q_r[2]); rhi = smax(rhi, q_r[2]);
        end
        if ((bpos && !a.b_hi_valid) || (bneg && !a.b_lo_valid)) begin
          rlo = smin(rlo, '0); rhi = smax(rhi, '0);
        end
        lov = (a.a_lo_valid && bpos) || (a.a_hi_valid && bneg);
        hiv = (a.a_hi_valid && bpos) || (a.a_lo_valid && bneg);
        if (abnd && a.a_lo != iau_pkg::S64_MIN) begin
          m = smax(a.a_hi, -a.a_lo);
          rlo = lov ? smax(rlo, -m) : -m;
          rhi = hiv ? smin(rhi, m) : m;
          lov = 1'b1; hiv = 1'b1;
        end
        if ((nn && dn) || (np && dp)) begin
          rlo = lov ? smax(rlo, '0) : '0;
          lov = 1'b1;
        end
        if ((nn && dp) || (np && dn)) begin
          rhi = hiv ? smin(rhi, '0) : '0;
          hiv = 1'b1;
        end
      end
      iau_pkg::ACT_MIN: begin
        lov = a.a_lo_valid && a.b_lo_valid;
        rlo = smin(a.a_lo, a.b_lo);
        hiv = a.a_hi_valid || a.b_hi_valid;
        rhi = (a.a_hi_valid && a.b_hi_valid) ? smin(a.a_hi, a.b_hi)
            : (a.a_hi_valid ? a.a_hi : a.b_hi);
      end
      iau_pkg::ACT_MAX: begin
        lov = a.a_lo_valid || a.b_lo_valid;
        rlo = (a.a_lo_valid && a.b_lo_valid) ? smax(a.a_lo, a.b_lo)
            : (a.a_lo_valid ? a.a_lo : a.b_lo);
        hiv = a.a_hi_valid && a.b_hi_valid;
        rhi = smax(a.a_hi, a.b_hi);
      end
      iau_pkg::ACT_ABS: begin
        if (abnd && a.a_lo != iau_pkg::S64_MIN) begin
          hiv = 1'b1;
          rhi = smax(-a.a_lo, a.a_hi);
        end
        lov = 1'b1;
        rlo = apos ? a.a_lo : '0;
      end
      iau_pkg::ACT_UNION: begin
        lov = a.a_lo_valid && a.b_lo_valid;
        rlo = smin(a.a_lo, a.b_lo);
        hiv = a.a_hi_valid && a.b_hi_valid;
        rhi = smax(a.a_hi, a.b_hi);
      end
      iau_pkg::ACT_CONTAINS: begin
        res_nxt.point_inside = !((a.a_lo_valid && a.b_lo < a.a_lo) ||
                                 (a.a_hi_valid && a.b_lo > a.a_hi));
      end
      default: begin
      end
    endcase
    res_nxt.r_lo_valid = lov;
    res_nxt.r_hi_valid = hiv;
    res_nxt.r_lo = lov ? rlo : '0;
    res_nxt.r_hi = hiv ? rhi : '0;
  end

  assign vld_out = v2_r;
  assign res_out = res_r;
endmodule
`default_nettype wire

/* hdl/iau_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module iau_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [135:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped while stalled");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[135:131] == 5'b0)
    else $error("pad bits set");
  a_zero_lo: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[128] |-> out_tdata[63:0] == 64'd0)
    else $error("undefined lower bound not zero");
  a_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[130] |-> !out_tdata[128] && !out_tdata[129])
    else $error("point flag with bounds");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
endmodule
bind int64_interval_arithmetic_unit_core iau_checker u_chk (.*);
`default_nettype wire

/* tb/sv/tb_int64_interval_arithmetic_unit_core.sv */
`timescale 1ns / 1ps
module tb_int64_interval_arithmetic_unit_core;

  localparam int LIMIT = 400000;
  localparam int TAIL = 100;

  typedef logic signed [63:0] s64_t;

  typedef struct {
    logic [3:0] action;
    s64_t a_lo, a_hi, b_lo, b_hi;
    logic alv, ahv, blv, bhv;
  } ivl_pair_t;

  typedef struct {
    s64_t r_lo, r_hi;
    logic rlv, rhv, pt_in;
  } ivl_res_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [263:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [135:0] out_tdata;

  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  int mismatches;
  ivl_res_t expected_bounds[$];

  int64_interval_arithmetic_unit_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---- interval arithmetic predictor ----
  function automatic logic add_fits(input s64_t a, input s64_t b, output s64_t r);
    logic signed [64:0] f;
    f = 65'(a) + 65'(b);
    r = f[63:0];
    return f[64] == f[63];
  endfunction

  function automatic logic sub_fits(input s64_t a, input s64_t b, output s64_t r);
    logic signed [64:0] f;
    f = 65'(a) - 65'(b);
    r = f[63:0];
    return f[64] == f[63];
  endfunction

  function automatic s64_t clamp_mul(input s64_t a, input s64_t b,
                                     inout logic lov, inout logic hiv);
    logic signed [127:0] f;
    f = 128'(a) * 128'(b);
    if (f[127:63] == '0 || f[127:63] == '1) return f[63:0];
    if ((a > 0) == (b > 0)) begin
      hiv = 1'b0;
      return iau_pkg::S64_MAX;
    end
    lov = 1'b0;
    return iau_pkg::S64_MIN;
  endfunction

  function automatic s64_t eucl_div(input s64_t a, input s64_t b);
    s64_t q, r;
    if (a == iau_pkg::S64_MIN && b == -64'sd1) return iau_pkg::S64_MIN;
    q = a / b;
    r = a % b;
    if (r < 0) q = (b > 0) ? q - 1 : q + 1;
    return q;
  endfunction

  function automatic s64_t smin(input s64_t x, input s64_t y);
    return x < y ? x : y;
  endfunction

  function automatic s64_t smax(input s64_t x, input s64_t y);
    return x > y ? x : y;
  endfunction

  function automatic ivl_res_t interval_result(input ivl_pair_t p);
    ivl_res_t r;
    s64_t v1, v2, v3, v4, m;
    logic apos, bpos, bneg, abnd, bbnd, nn, np, dn, dp;
    r = '{0, 0, 1'b0, 1'b0, 1'b0};
    apos = p.alv && p.a_lo > 0;
    bpos = p.blv && p.b_lo > 0;
    bneg = p.bhv && p.b_hi < 0;
    abnd = p.alv && p.ahv;
    bbnd = p.blv && p.bhv;
    case (p.action)
      iau_pkg::ACT_ADD: begin
        r.rlv = p.alv && p.blv && add_fits(p.a_lo, p.b_lo, r.r_lo);
        r.rhv = p.ahv && p.bhv && add_fits(p.a_hi, p.b_hi, r.r_hi);
      end
      iau_pkg::ACT_SUB: begin
        r.rlv = p.alv && p.bhv && sub_fits(p.a_lo, p.b_hi, r.r_lo);
        r.rhv = p.ahv && p.blv && sub_fits(p.a_hi, p.b_lo, r.r_hi);
      end
      iau_pkg::ACT_MUL: begin
        if (abnd && bbnd) begin
          r.rlv = 1'b1;
          r.rhv = 1'b1;
          v1 = clamp_mul(p.a_lo, p.b_lo, r.rlv, r.rhv);
          v2 = clamp_mul(p.a_lo, p.b_hi, r.rlv, r.rhv);
          v3 = clamp_mul(p.a_hi, p.b_lo, r.rlv, r.rhv);
          v4 = clamp_mul(p.a_hi, p.b_hi, r.rlv, r.rhv);
          r.r_lo = smin(smin(v1, v2), smin(v3, v4));
          r.r_hi = smax(smax(v1, v2), smax(v3, v4));
        end else if ((p.ahv && bbnd && bpos) || (p.bhv && abnd && apos)) begin
          r.rhv = 1'b1;
          r.r_hi = clamp_mul(p.a_hi, p.b_hi, r.rlv, r.rhv);
        end else if ((p.alv && bbnd && bpos) || (p.blv && abnd && apos)) begin
          r.rlv = 1'b1;
          r.r_lo = clamp_mul(p.a_lo, p.b_lo, r.rlv, r.rhv);
        end
      end
      iau_pkg::ACT_DIV: begin
        r.r_lo = iau_pkg::S64_MAX;
        r.r_hi = iau_pkg::S64_MIN;
        if (p.alv && p.blv && p.b_lo != 0) begin
          v1 = eucl_div(p.a_lo, p.b_lo);
          r.r_lo = smin(r.r_lo, v1); r.r_hi = smax(r.r_hi, v1);
        end
        if (p.alv && p.bhv && p.b_hi != 0) begin
          v1 = eucl_div(p.a_lo, p.b_hi);
          r.r_lo = smin(r.r_lo, v1); r.r_hi = smax(r.r_hi, v1);
        end
        if (p.ahv && p.bhv && p.b_hi != 0) begin
          v1 = eucl_div(p.a_hi, p.b_hi);
          r.r_lo = smin(r.r_lo, v1); r.r_hi = smax(r.r_hi, v1);
        end
        if (p.ahv && p.blv && p.b_lo != 0) begin
          v1 = eucl_div(p.a_hi, p.b_lo);
          r.r_lo = smin(r.r_lo, v1); r.r_hi = smax(r.r_hi, v1);
        end
        if ((bpos && !p.bhv) || (bneg && !p.blv)) begin
          r.r_lo = smin(r.r_lo, 0); r.r_hi = smax(r.r_hi, 0);
        end
        r.rlv = (p.alv && bpos) || (p.ahv && bneg);
        r.rhv = (p.ahv && bpos) || (p.alv && bneg);
        if (abnd && p.a_lo != iau_pkg::S64_MIN) begin
          m = smax(p.a_hi, -p.a_lo);
          r.r_lo = r.rlv ? smax(r.r_lo, -m) : -m;
          r.r_hi = r.rhv ? smin(r.r_hi, m) : m;
          r.rlv = 1'b1;
          r.rhv = 1'b1;
        end
        nn = p.alv && p.a_lo >= 0;
        dn = p.blv && p.b_lo >= 0;
        np = p.ahv && p.a_hi <= 0;
        dp = p.bhv && p.b_hi <= 0;
        if ((nn && dn) || (np && dp)) begin
          r.r_lo = r.rlv ? smax(r.r_lo, 0) : 0;
          r.rlv = 1'b1;
        end
        if ((nn && dp) || (np && dn)) begin
          r.r_hi = r.rhv ? smin(r.r_hi, 0) : 0;
          r.rhv = 1'b1;
        end
      end
      iau_pkg::ACT_MIN: begin
        r.rlv = p.alv && p.blv;
        r.r_lo = smin(p.a_lo, p.b_lo);
        r.rhv = p.ahv || p.bhv;
        r.r_hi = (p.ahv && p.bhv) ? smin(p.a_hi, p.b_hi) : (p.ahv ? p.a_hi : p.b_hi);
      end
      iau_pkg::ACT_MAX: begin
        r.rlv = p.alv || p.blv;
        r.r_lo = (p.alv && p.blv) ? smax(p.a_lo, p.b_lo) : (p.alv ? p.a_lo : p.b_lo);
        r.rhv = p.ahv && p.bhv;
        r.r_hi = smax(p.a_hi, p.b_hi);
      end
      iau_pkg::ACT_ABS: begin
        if (abnd && p.a_lo != iau_pkg::S64_MIN) begin
          r.rhv = 1'b1;
          r.r_hi = smax(-p.a_lo, p.a_hi);
        end
        r.rlv = 1'b1;
        r.r_lo = apos ? p.a_lo : 0;
      end
      iau_pkg::ACT_UNION: begin
        r.rlv = p.alv && p.blv;
        r.r_lo = smin(p.a_lo, p.b_lo);
        r.rhv = p.ahv && p.bhv;
        r.r_hi = smax(p.a_hi, p.b_hi);
      end
      iau_pkg::ACT_CONTAINS:
        r.pt_in = !((p.alv && p.b_lo < p.a_lo) || (p.ahv && p.b_lo > p.a_hi));
      default: ;
    endcase
    if (!r.rlv) r.r_lo = 0;
    if (!r.rhv) r.r_hi = 0;
    return r;
  endfunction

  // ---- beat driver ----
  task automatic send_pair(input ivl_pair_t p);
    logic rdy;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {p.bhv, p.blv, p.b_hi, p.b_lo, p.ahv, p.alv, p.a_hi, p.a_lo, p.action};
    forever begin
      #1 rdy = in_tready;
      @(posedge clk);
      if (rdy) break;
      @(negedge clk);
    end
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_bounds.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk)
    out_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

  // ---- monitor and checker ----
  always begin
    logic iv, ir, ov, orr;
    logic [263:0] id;
    logic [135:0] od;
    ivl_pair_t p;
    ivl_res_t e;
    @(negedge clk);
    #1;
    iv = in_tvalid; ir = in_tready; id = in_tdata;
    ov = out_tvalid; orr = out_tready; od = out_tdata;
    @(posedge clk);
    if (rst_n && iv && ir) begin
      p.action = id[3:0];
      p.a_lo = id[67:4]; p.a_hi = id[131:68];
      p.alv = id[132]; p.ahv = id[133];
      p.b_lo = id[197:134]; p.b_hi = id[261:198];
      p.blv = id[262]; p.bhv = id[263];
      expected_bounds.push_back(interval_result(p));
    end
    if (rst_n && ov && orr) begin
      if (expected_bounds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", od);
      end else begin
        e = expected_bounds.pop_front();
        if (od[63:0] !== e.r_lo || od[127:64] !== e.r_hi || od[128] !== e.rlv ||
            od[129] !== e.rhv || od[130] !== e.pt_in || od[135:131] !== 5'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("exp lo=%0d hi=%0d lv=%b hv=%b in=%b | got lo=%0d hi=%0d lv=%b hv=%b in=%b z=%b",
                     e.r_lo, e.r_hi, e.rlv, e.rhv, e.pt_in,
                     $signed(od[63:0]), $signed(od[127:64]), od[128], od[129], od[130],
                     od[135:131]);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("int64_interval_arithmetic_unit_core: mismatch");
      $finish;
    end
  end

  // ---- stimulus ----
  function automatic s64_t pick_bound;
    case ($urandom_range(11))
      0: return iau_pkg::S64_MIN;
      1: return iau_pkg::S64_MAX;
      2: return 0;
      3: return 1;
      4: return -1;
      5: return s64_t'($urandom_range(20)) - 10;
      6: return s64_t'($signed($urandom()));
      7: return iau_pkg::S64_MAX - $urandom_range(3);
      8: return iau_pkg::S64_MIN + $urandom_range(3);
      9: return {$urandom(), $urandom()} >>> $urandom_range(63);
      10: return s64_t'($urandom_range(1 << 20)) << $urandom_range(44);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic ivl_pair_t mk(input logic [3:0] act, input s64_t alo, input s64_t ahi,
                                   input s64_t blo, input s64_t bhi, input logic [3:0] v);
    ivl_pair_t p;
    p = '{act, alo, ahi, blo, bhi, v[0], v[1], v[2], v[3]};
    return p;
  endfunction

  function automatic ivl_pair_t random_pair;
    ivl_pair_t p;
    s64_t t;
    p.action = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
    p.a_lo = pick_bound(); p.a_hi = pick_bound();
    p.b_lo = pick_bound(); p.b_hi = pick_bound();
    if ($urandom_range(3) != 0) begin
      if (p.a_lo > p.a_hi) begin t = p.a_lo; p.a_lo = p.a_hi; p.a_hi = t; end
      if (p.b_lo > p.b_hi) begin t = p.b_lo; p.b_lo = p.b_hi; p.b_hi = t; end
    end
    if (p.action == iau_pkg::ACT_CONTAINS && $urandom_range(1))
      p.b_lo = ($urandom_range(1) ? p.a_lo : p.a_hi) + s64_t'($urandom_range(2)) - 1;
    {p.alv, p.ahv, p.blv, p.bhv} = ($urandom_range(1)) ? 4'hf : 4'($urandom());
    return p;
  endfunction

  task automatic test_directed_cases;
    send_pair(mk(iau_pkg::ACT_ADD, iau_pkg::S64_MAX, iau_pkg::S64_MAX, 1, 1, 4'hf));
    send_pair(mk(iau_pkg::ACT_ADD, iau_pkg::S64_MIN, -5, -1, 3, 4'hf));
    send_pair(mk(iau_pkg::ACT_SUB, iau_pkg::S64_MIN, iau_pkg::S64_MAX, 1, -1, 4'hf));
    send_pair(mk(iau_pkg::ACT_SUB, 3, 9, -2, 4, 4'h5));
    send_pair(mk(iau_pkg::ACT_MUL, iau_pkg::S64_MIN, iau_pkg::S64_MAX, -1, 2, 4'hf));
    send_pair(mk(iau_pkg::ACT_MUL, -7, 5, 3, 11, 4'hf));
    send_pair(mk(iau_pkg::ACT_MUL, 0, iau_pkg::S64_MAX, 4, 9, 4'he));
    send_pair(mk(iau_pkg::ACT_MUL, iau_pkg::S64_MAX, 0, 2, 9, 4'hd));
    send_pair(mk(iau_pkg::ACT_MUL, 2, 9, -3, 0, 4'h7));
    send_pair(mk(iau_pkg::ACT_DIV, iau_pkg::S64_MIN, iau_pkg::S64_MAX, -1, -1, 4'hf));
    send_pair(mk(iau_pkg::ACT_DIV, -7, 7, 0, 0, 4'hf));
    send_pair(mk(iau_pkg::ACT_DIV, -7, 13, 2, 0, 4'h7));
    send_pair(mk(iau_pkg::ACT_DIV, -9, -4, 0, -3, 4'hb));
    send_pair(mk(iau_pkg::ACT_DIV, iau_pkg::S64_MIN, 5, -3, 2, 4'hf));
    send_pair(mk(iau_pkg::ACT_MIN, iau_pkg::S64_MIN, 4, 2, iau_pkg::S64_MAX, 4'h9));
    send_pair(mk(iau_pkg::ACT_MAX, iau_pkg::S64_MIN, 4, 2, iau_pkg::S64_MAX, 4'h6));
    send_pair(mk(iau_pkg::ACT_ABS, iau_pkg::S64_MIN, 3, 0, 0, 4'h3));
    send_pair(mk(iau_pkg::ACT_ABS, -9, 4, 0, 0, 4'h3));
    send_pair(mk(iau_pkg::ACT_ABS, 5, 2, 0, 0, 4'h1));
    send_pair(mk(iau_pkg::ACT_UNION, 9, 1, -3, 20, 4'hf));
    send_pair(mk(iau_pkg::ACT_CONTAINS, -3, 3, 3, 0, 4'h3));
    send_pair(mk(iau_pkg::ACT_CONTAINS, -3, 3, 4, 0, 4'h3));
    send_pair(mk(iau_pkg::ACT_CONTAINS, -3, 3, iau_pkg::S64_MIN, 0, 4'h2));
    send_pair(mk(4'd15, iau_pkg::S64_MAX, iau_pkg::S64_MAX, iau_pkg::S64_MIN,
                 iau_pkg::S64_MIN, 4'hf));
    send_pair(mk(4'd9, -1, -1, -1, -1, 4'hf));
    drain();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int n);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_pair(random_pair());
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cycles = 0;
    mismatches = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_random_phase(0, 0, 220);
    test_random_phase(76, 0, 200);
    test_random_phase(0, 76, 200);
    test_random_phase(35, 35, 230);
    repeat (TAIL) @(negedge clk);
    if (mismatches == 0 && expected_bounds.size() == 0)
      $display("int64_interval_arithmetic_unit_core: match");
    else
      $display("int64_interval_arithmetic_unit_core: mismatch");
    $finish;
  end

endmodule
